### hdl/bounded_ordered_list_engine_macros.svh
// Assertion macros used by the list engine datapath.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define BOLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bole_pkg.sv
// Shared types, constants and helpers for the bounded ordered list engine.
package bole_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DATA_W      = 32;
  localparam int OPC_W       = 3;
  localparam int STS_W       = 2;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int AW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_POS   = 3'd1,
    OP_ADD_TAIL  = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_POS   = 3'd4,
    OP_REM_TAIL  = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_DUMP      = 3'd7
  } opcode_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    EK_NONE   = 2'd0,
    EK_STATUS = 2'd1,
    EK_ENTRY  = 2'd2,
    EK_MISS   = 2'd3
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       decode;
    logic       rd;
    logic       wr_move;
    logic       step;
    logic       commit;
    emit_kind_t emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic reject;
    logic is_ins;
    logic is_rem;
    logic is_search;
    logic at_end;
    logic hit;
    logic dump_last;
  } dp_sts_t;

  // 1-based position to 0-based index, clamped to 0..hi
  function automatic logic [CW-1:0] clamp_idx(input logic signed [DATA_W-1:0] pos,
                                               input logic [CW-1:0] hi);
    logic signed [DATA_W-1:0] pm1;
    logic [DATA_W-1:0]        hi_w;
    pm1  = pos - 32'sd1;
    hi_w = DATA_W'(hi);
    if (pos < 32'sd1) begin
      return '0;
    end else if ($unsigned(pm1) > hi_w) begin
      return hi;
    end else begin
      return pm1[CW-1:0];
    end
  endfunction

endpackage

### hdl/bole_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bole_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bole_dp.sv
// Datapath: operand latches, list count, walk pointer, entry RAM and result registers.
`include "bounded_ordered_list_engine_macros.svh"

module bole_dp import bole_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic signed [DATA_W-1:0] in_position,
  input  ctrl_cmd_t                cmd,
  output dp_sts_t                  sts,
  output logic                     out_valid,
  output logic [STS_W-1:0]         out_status,
  output logic [IDX_W-1:0]         out_entry_index,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_last
);

  opcode_t                  op_r;
  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] pos_r;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            ptr_r, ptr_nxt;
  logic [CW-1:0]            end_r, end_nxt;
  status_t                  st_r, st_nxt;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic [DATA_W-1:0]        out_val_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic                     out_last_r;

  logic              is_ins, is_rem, is_search, is_dump;
  logic              full, empty;
  logic [CW-1:0]     cnt_m1, dump_end;
  logic [CW-1:0]     rd_ptr;
  logic [DATA_W-1:0] rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;

  assign is_ins    = (op_r == OP_ADD_FRONT) || (op_r == OP_ADD_POS) || (op_r == OP_ADD_TAIL);
  assign is_rem    = (op_r == OP_REM_FRONT) || (op_r == OP_REM_POS) || (op_r == OP_REM_TAIL);
  assign is_search = (op_r == OP_SEARCH);
  assign is_dump   = (op_r == OP_DUMP);
  assign full      = (count_r == CW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign cnt_m1    = count_r - 1'b1;
  assign dump_end  = (32'(count_r) > 32'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : count_r;

  assign sts.reject    = (is_ins && full) || ((is_rem || is_dump) && empty);
  assign sts.is_ins    = is_ins;
  assign sts.is_rem    = is_rem;
  assign sts.is_search = is_search;
  assign sts.at_end    = (ptr_r == end_r);
  assign sts.hit       = (rdata == val_r);
  assign sts.dump_last = ({1'b0, ptr_r} + 1'b1) == {1'b0, end_r};

  // source of a shift: one below for insert, one above for remove
  always_comb begin
    rd_ptr = ptr_r;
    if (is_ins) begin
      rd_ptr = ptr_r - 1'b1;
    end else if (is_rem) begin
      rd_ptr = ptr_r + 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = rdata;
    if (cmd.wr_move) begin
      we = 1'b1;
    end else if (cmd.commit && is_ins) begin
      we    = 1'b1;
      waddr = end_r[AW-1:0];
      wdata = val_r;
    end
  end

  bole_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    end_nxt   = end_r;
    st_nxt    = st_r;
    if (cmd.decode) begin
      st_nxt = ST_OK;
      if (is_ins) begin
        if (full) st_nxt = ST_FULL;
        ptr_nxt = count_r;
        case (op_r)
          OP_ADD_FRONT: end_nxt = '0;
          OP_ADD_POS:   end_nxt = clamp_idx(pos_r, count_r);
          default:      end_nxt = count_r;
        endcase
      end else if (is_rem) begin
        if (empty) st_nxt = ST_EMPTY;
        end_nxt = cnt_m1;
        case (op_r)
          OP_REM_FRONT: ptr_nxt = '0;
          OP_REM_POS:   ptr_nxt = clamp_idx(pos_r, cnt_m1);
          default:      ptr_nxt = cnt_m1;
        endcase
      end else begin
        if (is_dump && empty) st_nxt = ST_EMPTY;
        ptr_nxt = '0;
        end_nxt = is_search ? count_r : dump_end;
      end
    end
    if (cmd.step) begin
      ptr_nxt = is_ins ? ptr_r - 1'b1 : ptr_r + 1'b1;
    end
    if (cmd.commit) begin
      count_nxt = is_ins ? count_r + 1'b1 : count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= (cmd.emit != EK_NONE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode_t'(in_opcode);
      val_r <= in_item_value;
      pos_r <= in_position;
    end
    ptr_r <= ptr_nxt;
    end_r <= end_nxt;
    st_r  <= st_nxt;
    case (cmd.emit)
      EK_STATUS: begin
        out_status_r <= st_r;
        out_idx_r    <= '0;
        out_val_r    <= '0;
        out_last_r   <= 1'b1;
      end
      EK_MISS: begin
        out_status_r <= ST_NOT_FOUND;
        out_idx_r    <= '0;
        out_val_r    <= '0;
        out_last_r   <= 1'b1;
      end
      EK_ENTRY: begin
        out_status_r <= ST_OK;
        out_idx_r    <= IDX_W'(ptr_r);
        out_val_r    <= rdata;
        out_last_r   <= is_search || sts.dump_last;
      end
      default: begin
      end
    endcase
    out_cnt_r <= CNT_W'(count_r);
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;
  assign out_entry_value = out_val_r;
  assign out_entry_count = out_cnt_r;
  assign out_last        = out_last_r;

  `BOLE_ASSERT_SAME(a_cnt_bound, 1'b1, count_r <= CW'(CAPACITY), "count beyond capacity")
  `BOLE_ASSERT_NEXT(a_ins_grow, cmd.commit && is_ins, count_r == $past(count_r) + 1'b1, "no grow")
  `BOLE_ASSERT_NEXT(a_last_gap, out_valid_r && out_last_r, !out_valid_r, "result straight after final result")
  `BOLE_ASSERT_SAME(a_empty_cnt, out_valid_r && (out_status_r == ST_EMPTY), out_cnt_r == '0, "empty status with entries")

endmodule

### hdl/bole_ctrl.sv
// Controller: sequences decode, entry shifts, scans and result transfers.
module bole_ctrl import bole_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dp_sts_t   sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DECODE   = 10'b0000000010,
    S_MOVE_CHK = 10'b0000000100,
    S_MOVE_RD  = 10'b0000001000,
    S_MOVE_WR  = 10'b0000010000,
    S_COMMIT   = 10'b0000100000,
    S_EMIT     = 10'b0001000000,
    S_SCAN_CHK = 10'b0010000000,
    S_SCAN_RD  = 10'b0100000000,
    S_SCAN_EV  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.emit  = EK_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.reject) begin
          state_nxt = S_EMIT;
        end else if (sts.is_ins || sts.is_rem) begin
          state_nxt = S_MOVE_CHK;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_MOVE_CHK: begin
        state_nxt = sts.at_end ? S_COMMIT : S_MOVE_RD;
      end
      S_MOVE_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.wr_move = 1'b1;
        cmd.step    = 1'b1;
        state_nxt   = S_MOVE_CHK;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit  = EK_STATUS;
        state_nxt = S_IDLE;
      end
      S_SCAN_CHK: begin
        if (sts.at_end) begin
          cmd.emit  = EK_MISS;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (sts.is_search) begin
          if (sts.hit) begin
            cmd.emit  = EK_ENTRY;
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_SCAN_CHK;
          end
        end else begin
          cmd.emit  = EK_ENTRY;
          cmd.step  = 1'b1;
          state_nxt = sts.dump_last ? S_IDLE : S_SCAN_CHK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hdl/bounded_ordered_list_engine.sv
// Top level: bounded ordered list engine, controller plus datapath.
// Add/remove: decode, one RAM read and one write per entry shifted, commit, status result.
// Search: entries are compared in order; a hit returns index and value, a miss not-found.
// Dump: entries up to MAX_RESULTS come out in order; rejected operations give a status only.
// One transfer at a time: busy drops as the final result shows; the receiver cannot stall.
// Synchronous active-low reset empties the list; entry storage is not cleared.
module bounded_ordered_list_engine import bole_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OPC_W-1:0]         in_opcode,
  input  logic signed [DATA_W-1:0] in_item_value,
  input  logic signed [DATA_W-1:0] in_position,
  output logic                     out_valid,
  output logic [STS_W-1:0]         out_status,
  output logic [IDX_W-1:0]         out_entry_index,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_last
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  bole_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bole_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .in_position     (in_position),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

### sim/tb_bounded_ordered_list_engine.sv
// Testbench for the bounded ordered list engine: directed and random ops against a queue model.
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  typedef struct {
    opcode_t                  op;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] pos;
  } list_cmd_t;

  typedef struct {
    status_t                  status;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } list_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [OPC_W-1:0]         in_opcode;
  logic signed [DATA_W-1:0] in_item_value;
  logic signed [DATA_W-1:0] in_position;
  logic                     out_valid;
  logic [STS_W-1:0]         out_status;
  logic [IDX_W-1:0]         out_entry_index;
  logic signed [DATA_W-1:0] out_entry_value;
  logic [CNT_W-1:0]         out_entry_count;
  logic                     out_last;

  list_cmd_t                pending_cmds[$];
  list_result_t             expected_results[$];
  logic signed [DATA_W-1:0] shadow_list[$];
  logic signed [DATA_W-1:0] value_pool[6];

  list_cmd_t cur_cmd;
  logic      in_took;
  logic      no_idle;
  int        gap_left;
  int        mismatches;
  int        n_accepted, n_checked, n_adds, n_removes, n_searches, n_dumps;
  int        n_full, n_empty, n_hits;

  bounded_ordered_list_engine uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_item_value   (in_item_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
    mismatches++;
  endtask

  // 1-based position to 0-based index, clamped to 0..hi
  function automatic int pos_to_index(input logic signed [DATA_W-1:0] pos, input int hi);
    longint idx;
    idx = longint'(pos) - 1;
    if (idx < 0) idx = 0;
    if (idx > hi) idx = hi;
    return int'(idx);
  endfunction

  task automatic queue_result(input status_t st, input int idx,
                              input logic signed [DATA_W-1:0] val, input logic lst);
    list_result_t r;
    r.status = st;
    r.index  = IDX_W'(idx);
    r.value  = val;
    r.count  = CNT_W'(shadow_list.size());
    r.last   = lst;
    expected_results.push_back(r);
  endtask

  task automatic apply_list_op(input opcode_t op, input logic signed [DATA_W-1:0] val,
                               input logic signed [DATA_W-1:0] pos);
    int n;
    int at;
    int hit;
    n = shadow_list.size();
    case (op)
      OP_ADD_FRONT, OP_ADD_POS, OP_ADD_TAIL: begin
        n_adds++;
        if (n >= CAPACITY) begin
          n_full++;
          queue_result(ST_FULL, 0, '0, 1'b1);
        end else begin
          at = (op == OP_ADD_FRONT) ? 0 : (op == OP_ADD_TAIL) ? n : pos_to_index(pos, n);
          shadow_list.insert(at, val);
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_REM_FRONT, OP_REM_POS, OP_REM_TAIL: begin
        n_removes++;
        if (n == 0) begin
          n_empty++;
          queue_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          at = (op == OP_REM_FRONT) ? 0 : (op == OP_REM_TAIL) ? n - 1 : pos_to_index(pos, n - 1);
          shadow_list.delete(at);
          queue_result(ST_OK, 0, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        n_searches++;
        hit = -1;
        for (int i = 0; i < n; i++)
          if (hit < 0 && shadow_list[i] == val) hit = i;
        if (hit >= 0) begin
          n_hits++;
          queue_result(ST_OK, hit, val, 1'b1);
        end else begin
          queue_result(ST_NOT_FOUND, 0, '0, 1'b1);
        end
      end
      default: begin
        n_dumps++;
        if (n == 0) begin
          n_empty++;
          queue_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          if (n > MAX_RESULTS) n = MAX_RESULTS;
          for (int i = 0; i < n; i++)
            queue_result(ST_OK, i, shadow_list[i], (i == n - 1));
        end
      end
    endcase
  endtask

  task automatic push_cmd(input opcode_t op, input logic signed [DATA_W-1:0] val,
                          input logic signed [DATA_W-1:0] pos);
    list_cmd_t c;
    c.op    = op;
    c.value = val;
    c.pos   = pos;
    pending_cmds.push_back(c);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return value_pool[$urandom_range(0, 5)];
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFFFFFF;
        1: return 32'sh80000000;
        2: return -32'sd1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 18);
    if (r < 15) return -$signed($urandom_range(1, 40));
    return $urandom;
  endfunction

  // phase: 0 filling, 1 draining, 2 anything
  function automatic opcode_t pick_op(input int phase);
    int r;
    r = $urandom_range(0, 99);
    if (phase == 2) return opcode_t'($urandom_range(0, 7));
    if (r < 20) return (r < 12) ? OP_SEARCH : OP_DUMP;
    if ((phase == 0) == (r < 85)) return opcode_t'($urandom_range(OP_ADD_FRONT, OP_ADD_TAIL));
    return opcode_t'($urandom_range(OP_REM_FRONT, OP_REM_TAIL));
  endfunction

  // driver: one command per start, gaps drawn per transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !in_took) begin
      end else if (gap_left != 0) begin
        gap_left      = gap_left - 1;
        start         <= 1'b0;
        in_opcode     <= OPC_W'($urandom_range(0, 7));
        in_item_value <= $urandom;
        in_position   <= $urandom;
      end else if (pending_cmds.size() != 0) begin
        cur_cmd       = pending_cmds.pop_front();
        in_opcode     <= cur_cmd.op;
        in_item_value <= cur_cmd.value;
        in_position   <= cur_cmd.pos;
        start         <= 1'b1;
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        gap_left = no_idle ? 0 : $urandom_range(0, 11);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check results against the oldest expectation, then model new transfers
  always @(posedge clk) begin : monitor
    list_result_t want;
    in_took <= start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, 0);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (out_status !== want.status) report_mismatch("status", out_status, want.status);
          if (out_entry_index !== want.index)
            report_mismatch("entry_index", out_entry_index, want.index);
          if (out_entry_value !== want.value)
            report_mismatch("entry_value", out_entry_value, want.value);
          if (out_entry_count !== want.count)
            report_mismatch("entry_count", out_entry_count, want.count);
          if (out_last !== want.last) report_mismatch("last", out_last, want.last);
        end
      end
      if (start && !busy) begin
        n_accepted++;
        apply_list_op(opcode_t'(in_opcode), in_item_value, in_position);
      end
    end
  end

  initial begin
    int phase;
    int plen;
    int n_rand;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = '0;
    in_item_value = '0;
    in_position   = '0;
    in_took       = 1'b0;
    no_idle       = 1'b0;
    gap_left      = 0;
    mismatches    = 0;
    n_accepted = 0; n_checked = 0; n_adds = 0; n_removes = 0; n_searches = 0; n_dumps = 0;
    n_full = 0; n_empty = 0; n_hits = 0;

    value_pool[0] = 32'sd7;
    value_pool[1] = -32'sd7;
    for (int i = 2; i < 6; i++) value_pool[i] = $urandom;

    // directed: empty list, extreme values and positions, duplicates
    push_cmd(OP_DUMP, '0, '0);
    push_cmd(OP_SEARCH, '0, '0);
    push_cmd(OP_REM_FRONT, '0, '0);
    push_cmd(OP_REM_POS, '0, 32'sd3);
    push_cmd(OP_REM_TAIL, '0, '0);
    push_cmd(OP_ADD_FRONT, 32'sh7FFFFFFF, '0);
    push_cmd(OP_ADD_TAIL, 32'sh80000000, '0);
    push_cmd(OP_ADD_POS, 32'sd5, 32'sh80000000);
    push_cmd(OP_ADD_POS, -32'sd1, 32'sh7FFFFFFF);
    push_cmd(OP_ADD_POS, '0, 32'sd2);
    push_cmd(OP_ADD_POS, 32'sd5, '0);
    push_cmd(OP_SEARCH, 32'sd5, '0);
    push_cmd(OP_SEARCH, -32'sd1, '0);
    push_cmd(OP_SEARCH, 32'sd12345, '0);
    push_cmd(OP_DUMP, '0, '0);
    push_cmd(OP_REM_POS, '0, 32'sh80000000);
    push_cmd(OP_REM_POS, '0, 32'sh7FFFFFFF);
    push_cmd(OP_REM_POS, '0, 32'sd2);
    push_cmd(OP_DUMP, '0, '0);
    push_cmd(OP_REM_TAIL, '0, '0);
    push_cmd(OP_REM_FRONT, '0, '0);
    push_cmd(OP_DUMP, '0, '0);

    // random: fill and drain phases so full and empty are both reached
    n_rand = 0;
    while (n_rand < 340) begin
      phase = $urandom_range(0, 2);
      plen  = $urandom_range(15, 40);
      for (int i = 0; i < plen; i++) begin
        push_cmd(pick_op(phase), pick_value(), pick_pos());
        n_rand++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("%0d operations: %0d adds (%0d refused full), %0d removes,",
             n_accepted, n_adds, n_full, n_removes);
    $display("%0d searches (%0d hits), %0d dumps, %0d results checked, %0d empty-list rejects",
             n_searches, n_hits, n_dumps, n_checked, n_empty);
    if (mismatches == 0)
      $display("tb_bounded_ordered_list_engine OK");
    else
      $display("tb_bounded_ordered_list_engine NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout at %0t", $time);
    $display("tb_bounded_ordered_list_engine NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bole_pkg.sv
hdl/bole_ram.sv
hdl/bole_dp.sv
hdl/bole_ctrl.sv
hdl/bounded_ordered_list_engine.sv
sim/tb_bounded_ordered_list_engine.sv
